// ===== rtl/fl_ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// fl_ptw_pkg: shared types and constants of the four-level page table walker
// Request and result structs, mode and kind codes, walk levels and the
// reset values of the safe memory windows.
// ----------------------------------------------------------------------------
package fl_ptw_pkg;

  // physical, virtual and entry widths
  localparam int PA_W  = 52;
  localparam int VA_W  = 48;
  localparam int PTE_W = 64;
  localparam int SZ_W  = 53;
  localparam int LIM_W = 54;

  // configuration port
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 53;
  localparam int CFG_REG_COUNT = 6;

  // window count default
  localparam int NUM_WINDOWS_DEF = 3;

  // reset image of the first window, the others come up disabled
  localparam logic [PA_W-1:0] WIN0_BASE_RST = 52'h0_0000_0000_1000;
  localparam logic [SZ_W-1:0] WIN0_SIZE_RST = 53'h0_0000_3FFF_F000;

  // request mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_RESP  = 1'b1;

  // result kind codes
  localparam logic KIND_READ_REQ = 1'b0;
  localparam logic KIND_DONE     = 1'b1;

  // entry bits
  localparam int PTE_PRESENT = 0;
  localparam int PTE_LARGE   = 7;

  // walk levels: level of the entry being awaited
  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_1G   = 2'd1;
  localparam logic [1:0] LVL_2M   = 2'd2;
  localparam logic [1:0] LVL_LAST = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [PTE_W-1:0]  root_pointer;
    logic [VA_W-1:0]   virt_addr;
    logic [PTE_W-1:0]  entry_data;
    logic              read_ok;
  } ptw_in_t;

  typedef struct packed {
    logic             kind;
    logic [PA_W-1:0]  read_addr;
    logic [PA_W-1:0]  phys_addr;
    logic             fault;
  } ptw_out_t;

endpackage

// ===== rtl/four_level_page_table_walker_unit.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit: x86-64 style four-level table walker
// Takes start and entry response requests, emits entry read requests or a
// finished translation, checking every table address against safe windows.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : requests. mode 0 starts a walk (root_pointer, virt_addr), mode 1
//           returns the entry for the last read request (entry_data, read_ok).
//   out_* : one result per request: kind 0 is an entry read at read_addr,
//           kind 1 ends the walk with phys_addr or with fault set.
//   cfg_* : write-only window registers, index 2w = base, 2w+1 = size of
//           window w; size zero disables a window. Write only while idle.
// Timing
//   A request passes one input register, then a single pass of window compares
//   and entry muxing into the result register. Throughput is one request per
//   cycle while out_ready is high; the two register stages share one stall
//   signal, so the input register still fills while a result waits.
// Reset
//   rst_n low clears both stages and the walk state; window 0 returns to
//   base 0x1000, size 0x3FFFF000, the other windows are disabled.
// Stall
//   With out_ready low the result holds; in_ready drops once the input
//   register is also full.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit
  import fl_ptw_pkg::*;
#(
  parameter int NUM_WINDOWS = NUM_WINDOWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ptw_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ptw_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // window registers
  logic [PA_W-1:0]  win_base_r [NUM_WINDOWS];
  logic [SZ_W-1:0]  win_size_r [NUM_WINDOWS];
  logic [LIM_W-1:0] win_lim_r  [NUM_WINDOWS];
  logic             win_en_r   [NUM_WINDOWS];

  // pipeline and walk state
  logic             s1_valid_r;
  ptw_in_t          s1_data_r;
  logic             out_valid_r;
  ptw_out_t         out_data_r;
  ptw_out_t         out_data_nxt;
  logic             busy_r, busy_nxt;
  logic [1:0]       lvl_r, lvl_nxt;
  logic [VA_W-1:0]  va_r, va_nxt;

  logic             advance;
  logic             s1_fire;

  // combinational walk step
  logic [PA_W-1:0]  root_base;
  logic [PA_W-1:0]  pte_base;
  logic [PA_W-1:0]  req_base;
  logic [1:0]       req_lvl;
  logic [VA_W-1:0]  req_va;
  logic [8:0]       req_idx;
  logic [PA_W-1:0]  req_addr;
  logic             root_safe;
  logic             req_safe;
  logic             try_req;

  // frame number bits 51:12 of a root pointer or entry
  function automatic logic [PA_W-13:0] in_data_root_pfn(input logic [PTE_W-1:0] v);
    return v[PA_W-1:12];
  endfunction

  // window register writes, base+size limit kept alongside
  for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_win
    localparam bit HAS_REG = (2 * w + 1) < CFG_REG_COUNT;
    localparam logic [PA_W-1:0] BASE_RST = (w == 0) ? WIN0_BASE_RST : '0;
    localparam logic [SZ_W-1:0] SIZE_RST = (w == 0) ? WIN0_SIZE_RST : '0;

    logic wr_base;
    logic wr_size;

    if (HAS_REG) begin : g_dec
      assign wr_base = cfg_we && (cfg_index == CFG_IDX_W'(2 * w));
      assign wr_size = cfg_we && (cfg_index == CFG_IDX_W'(2 * w + 1));
    end else begin : g_nodec
      assign wr_base = 1'b0;
      assign wr_size = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        win_base_r[w] <= BASE_RST;
        win_size_r[w] <= SIZE_RST;
        win_lim_r[w]  <= LIM_W'(BASE_RST) + LIM_W'(SIZE_RST);
        win_en_r[w]   <= (SIZE_RST != '0);
      end else if (wr_base) begin
        win_base_r[w] <= cfg_wdata[PA_W-1:0];
        win_lim_r[w]  <= LIM_W'(cfg_wdata[PA_W-1:0]) + LIM_W'(win_size_r[w]);
      end else if (wr_size) begin
        win_size_r[w] <= cfg_wdata[SZ_W-1:0];
        win_lim_r[w]  <= LIM_W'(win_base_r[w]) + LIM_W'(cfg_wdata[SZ_W-1:0]);
        win_en_r[w]   <= (cfg_wdata[SZ_W-1:0] != '0);
      end
    end
  end

  // handshake: both stages move on one stall signal
  assign advance   = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // candidate table base, level and address for the next entry read
  always_comb begin
    root_base = {in_data_root_pfn(s1_data_r.root_pointer), 12'h000};
    pte_base  = {in_data_root_pfn(s1_data_r.entry_data), 12'h000};
    if (s1_data_r.mode == MODE_START) begin
      req_base = root_base;
      req_lvl  = LVL_TOP;
      req_va   = s1_data_r.virt_addr;
    end else begin
      req_base = pte_base;
      req_lvl  = lvl_r + 2'd1;
      req_va   = va_r;
    end
    unique case (req_lvl)
      LVL_TOP:  req_idx = req_va[47:39];
      LVL_1G:   req_idx = req_va[38:30];
      LVL_2M:   req_idx = req_va[29:21];
      LVL_LAST: req_idx = req_va[20:12];
      default:  req_idx = req_va[20:12];
    endcase
    req_addr = {req_base[PA_W-1:12], req_idx, 3'b000};
  end

  // safe window checks on the root base and the entry address
  always_comb begin
    root_safe = 1'b0;
    req_safe  = 1'b0;
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      root_safe = root_safe || (win_en_r[w] && (root_base >= win_base_r[w]) &&
                  (LIM_W'(root_base) < win_lim_r[w]));
      req_safe  = req_safe || (win_en_r[w] && (req_addr >= win_base_r[w]) &&
                  (LIM_W'(req_addr) < win_lim_r[w]));
    end
  end

  // walk decision: fault, large page, last level or next read
  always_comb begin
    out_data_nxt.kind      = KIND_DONE;
    out_data_nxt.read_addr = '0;
    out_data_nxt.phys_addr = '0;
    out_data_nxt.fault     = 1'b1;
    busy_nxt = 1'b0;
    lvl_nxt  = LVL_TOP;
    va_nxt   = va_r;
    try_req  = 1'b0;

    if (s1_data_r.mode == MODE_START) begin
      if (!busy_r) begin
        va_nxt  = s1_data_r.virt_addr;
        try_req = (root_base != '0) && root_safe;
      end
    end else if (busy_r && s1_data_r.read_ok &&
                 s1_data_r.entry_data[PTE_PRESENT]) begin
      priority if (lvl_r == LVL_1G && s1_data_r.entry_data[PTE_LARGE]) begin
        out_data_nxt.fault     = 1'b0;
        out_data_nxt.phys_addr = {s1_data_r.entry_data[51:30], va_r[29:0]};
      end else if (lvl_r == LVL_2M && s1_data_r.entry_data[PTE_LARGE]) begin
        out_data_nxt.fault     = 1'b0;
        out_data_nxt.phys_addr = {s1_data_r.entry_data[51:21], va_r[20:0]};
      end else if (lvl_r == LVL_LAST) begin
        out_data_nxt.fault     = 1'b0;
        out_data_nxt.phys_addr = {s1_data_r.entry_data[51:12], va_r[11:0]};
      end else begin
        try_req = 1'b1;
      end
    end

    if (try_req && req_safe) begin
      out_data_nxt.kind      = KIND_READ_REQ;
      out_data_nxt.read_addr = req_addr;
      out_data_nxt.fault     = 1'b0;
      busy_nxt = 1'b1;
      lvl_nxt  = req_lvl;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      lvl_r       <= LVL_TOP;
      va_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        busy_r <= busy_nxt;
        lvl_r  <= lvl_nxt;
        va_r   <= va_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // idle walker always sits at the top level
  a_idle_top: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> lvl_r == LVL_TOP)
    else $error("walker idle away from top level");

  // an issued read leaves the walker waiting for its response
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && out_data_nxt.kind == KIND_READ_REQ |=> busy_r)
    else $error("read request issued without busy");

  // a finished walk returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && out_data_nxt.kind == KIND_DONE |=> !busy_r)
    else $error("finished walk left busy");

  // read requests never carry a fault or a translation
  a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind == KIND_READ_REQ |->
      !out_data_r.fault && out_data_r.phys_addr == '0)
    else $error("read request with fault or address");

  // faults carry no addresses
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.fault |->
      out_data_r.phys_addr == '0 && out_data_r.read_addr == '0 &&
      out_data_r.kind == KIND_DONE)
    else $error("fault result with nonzero address");

endmodule
